### rtl/core/imu_cf_pkg.sv
// imu_cf_pkg: shared constants, tables and helpers for the attitude filter core
// no dependencies; imported by the lanes, the merge stage and the top level
`default_nettype none

package imu_cf_pkg;

	// parameter defaults
	localparam int NUM_SENSORS_DEF     = 2;
	localparam int ANGLE_FRAC_BITS_DEF = 8;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_RANGE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_W     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAG_LOW     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAG_HIGH    = 3'd3;
	localparam int CFG_DATA_W = 17;

	// register reset values
	localparam logic [1:0]  GYRO_RANGE_RST = 2'd0;
	localparam logic [15:0] BLEND_W_RST    = 16'd64225;
	localparam logic [16:0] MAG_LOW_RST    = 17'd8192;
	localparam logic [16:0] MAG_HIGH_RST   = 17'd32768;

	// cordic datapath
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int CORDIC_W     = 34;
	localparam int ACC_ANGLE_W  = 26;
	localparam int ACC_PRESCALE = 14;

	// gyro divisor: ten times sensitivity, times one hundred
	localparam int DIV_W = 17;

	function automatic logic [DIV_W-1:0] gyro_divisor(input logic [1:0] sel);
		logic [DIV_W-1:0] d;
		case (sel)
			2'd0:    d = 17'd131000;
			2'd1:    d = 17'd65500;
			2'd2:    d = 17'd32800;
			2'd3:    d = 17'd16400;
			default: d = 17'd131000;
		endcase
		return d;
	endfunction

	// atan(2^-i) in degrees times 65536
	function automatic logic signed [ACC_ANGLE_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
		logic signed [ACC_ANGLE_W-1:0] a;
		case (i)
			4'd0:    a = 26'sd2949120;
			4'd1:    a = 26'sd1740967;
			4'd2:    a = 26'sd919879;
			4'd3:    a = 26'sd466945;
			4'd4:    a = 26'sd234379;
			4'd5:    a = 26'sd117266;
			4'd6:    a = 26'sd58666;
			4'd7:    a = 26'sd29335;
			4'd8:    a = 26'sd14668;
			4'd9:    a = 26'sd7334;
			4'd10:   a = 26'sd3667;
			4'd11:   a = 26'sd1833;
			4'd12:   a = 26'sd917;
			4'd13:   a = 26'sd458;
			4'd14:   a = 26'sd229;
			4'd15:   a = 26'sd115;
			default: a = 26'sd0;
		endcase
		return a;
	endfunction

	// magnitude of a 16-bit sample
	function automatic logic [16:0] abs16(input logic signed [15:0] v);
		logic signed [16:0] w;
		w = {v[15], v};
		return v[15] ? 17'(-w) : 17'(w);
	endfunction

endpackage

`default_nettype wire

### rtl/core/imu_cf_ifs.sv
// imu_cf_ifs: valid/ready channel interfaces for samples, results and configuration
// depends on nothing but the field widths fixed here
`default_nettype none

interface imu_cf_in_if;
	logic               valid;
	logic               ready;
	logic               sensor_index;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic signed [15:0] gyro_z;
	logic [15:0]        elapsed_ms;
	modport source(output valid, sensor_index, accel_x, accel_y, accel_z, gyro_x, gyro_y,
		gyro_z, elapsed_ms, input ready);
	modport sink(input valid, sensor_index, accel_x, accel_y, accel_z, gyro_x, gyro_y,
		gyro_z, elapsed_ms, output ready);
endinterface

interface imu_cf_out_if;
	logic               valid;
	logic               ready;
	logic               sensor_tag;
	logic signed [31:0] yaw_out;
	logic signed [31:0] pitch_out;
	logic signed [31:0] roll_out;
	logic               accel_corrected;
	modport source(output valid, sensor_tag, yaw_out, pitch_out, roll_out, accel_corrected,
		input ready);
	modport sink(input valid, sensor_tag, yaw_out, pitch_out, roll_out, accel_corrected,
		output ready);
endinterface

interface imu_cf_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [16:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/imu_cf_gyro_lane.sv
// imu_cf_gyro_lane: one gyro axis, rate times time over sensitivity, added to or subtracted from the angle
// depends on imu_cf_pkg (divisor table); reciprocal multiplication with one correction step
`default_nettype none

module imu_cf_gyro_lane import imu_cf_pkg::*; #(
	parameter int FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [15:0] rate,
	input  wire logic [15:0]        ms,
	input  wire logic [1:0]         range_sel,
	input  wire logic               subtract,
	input  wire logic signed [31:0] angle_in,
	output logic                    done,
	output logic signed [31:0]      angle_out
);

	localparam int NUM_W = 32 + FRAC_BITS;
	// every divisor exceeds 2^14, so reciprocal and quotient fit in NUM_W - 14 bits
	localparam int REC_W = NUM_W - 14;
	localparam int LO_W  = NUM_W / 2;
	localparam int HI_W  = NUM_W - LO_W;
	localparam int EST_W = NUM_W + REC_W + 1;
	localparam int QD_W  = REC_W + DIV_W;
	localparam int SUM_W = NUM_W + 2;
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_MUL  = 3'd1;
	localparam logic [2:0] PH_NUM  = 3'd2;
	localparam logic [2:0] PH_REC  = 3'd3;
	localparam logic [2:0] PH_EST  = 3'd4;
	localparam logic [2:0] PH_BACK = 3'd5;
	localparam logic [2:0] PH_FIX  = 3'd6;
	localparam logic [2:0] PH_SUM  = 3'd7;
	localparam logic signed [SUM_W-1:0] MAX_V = SUM_W'(64'sd2147483647);
	localparam logic signed [SUM_W-1:0] MIN_V = SUM_W'(-64'sd2147483648);

	// reciprocals floor(2^NUM_W / divisor), estimate is at most one below the quotient
	localparam logic [REC_W-1:0] REC_0 =
		REC_W'((64'd1 << NUM_W) / 64'(gyro_divisor(2'd0)));
	localparam logic [REC_W-1:0] REC_1 =
		REC_W'((64'd1 << NUM_W) / 64'(gyro_divisor(2'd1)));
	localparam logic [REC_W-1:0] REC_2 =
		REC_W'((64'd1 << NUM_W) / 64'(gyro_divisor(2'd2)));
	localparam logic [REC_W-1:0] REC_3 =
		REC_W'((64'd1 << NUM_W) / 64'(gyro_divisor(2'd3)));

	logic [2:0]               phase_q;
	logic [16:0]              mag_q;
	logic [15:0]              ms_q;
	logic                     neg_q;
	logic signed [31:0]       angle_q;
	logic [DIV_W-1:0]         div_q;
	logic [REC_W-1:0]         rec_q;
	logic [32:0]              prod_q;
	logic [NUM_W-1:0]         num_q;
	logic [LO_W+REC_W-1:0]    plo_q;
	logic [HI_W+REC_W-1:0]    phi_q;
	logic [REC_W-1:0]         quo_q;
	logic [QD_W-1:0]          qd_q;
	logic                     done_q;
	logic signed [31:0]       result_q;
	logic [REC_W-1:0]         rec_sel;
	logic [EST_W-1:0]         est;
	logic [NUM_W-1:0]         rem;
	logic                     ge;
	logic signed [SUM_W-1:0]  inc;
	logic signed [SUM_W-1:0]  sum;

	// reciprocal of the selected divisor
	always_comb begin
		case (range_sel)
			2'd0:    rec_sel = REC_0;
			2'd1:    rec_sel = REC_1;
			2'd2:    rec_sel = REC_2;
			2'd3:    rec_sel = REC_3;
			default: rec_sel = REC_0;
		endcase
	end

	// quotient estimate, remainder and correction test
	assign est = (EST_W'(phi_q) << LO_W) + EST_W'(plo_q);
	assign rem = num_q - qd_q[NUM_W-1:0];
	assign ge  = rem >= NUM_W'(div_q);

	// signed increment and wide angle sum
	assign inc = neg_q ? -$signed(SUM_W'(quo_q)) : $signed(SUM_W'(quo_q));
	assign sum = SUM_W'(angle_q) + inc;

	// sequencer: multiply, reciprocal, correct, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_MUL;
						done_q  <= 1'b0;
					end
				end
				PH_MUL, PH_NUM, PH_REC, PH_EST, PH_BACK, PH_FIX: begin
					phase_q <= phase_q + 3'd1;
				end
				PH_SUM: begin
					phase_q <= PH_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					mag_q   <= abs16(rate);
					ms_q    <= ms;
					neg_q   <= rate[15] ^ subtract;
					angle_q <= angle_in;
					div_q   <= gyro_divisor(range_sel);
					rec_q   <= rec_sel;
				end
			end
			PH_MUL: prod_q <= 33'(mag_q * ms_q);
			PH_NUM: num_q <= NUM_W'({prod_q, {FRAC_BITS{1'b0}}}) + NUM_W'(div_q >> 1);
			PH_REC: begin
				plo_q <= num_q[LO_W-1:0] * rec_q;
				phi_q <= num_q[NUM_W-1:LO_W] * rec_q;
			end
			PH_EST:  quo_q <= est[NUM_W +: REC_W];
			PH_BACK: qd_q <= quo_q * div_q;
			PH_FIX: begin
				if (ge) begin
					quo_q <= quo_q + REC_W'(1);
				end
			end
			PH_SUM: begin
				if (sum > MAX_V) begin
					result_q <= 32'sh7FFFFFFF;
				end else if (sum < MIN_V) begin
					result_q <= 32'sh80000000;
				end else begin
					result_q <= sum[31:0];
				end
			end
			default: ;
		endcase
	end

	assign done      = done_q;
	assign angle_out = result_q;

endmodule

`default_nettype wire

### rtl/core/imu_cf_cordic_lane.sv
// imu_cf_cordic_lane: vectoring cordic, atan2 of two accelerometer axes in degrees x 65536
// depends on imu_cf_pkg (angle table, widths); one micro-rotation per cycle
`default_nettype none

module imu_cf_cordic_lane import imu_cf_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic signed [15:0]            num,
	input  wire logic signed [15:0]            den,
	output logic                               done,
	output logic signed [ACC_ANGLE_W-1:0]      angle
);

	logic                          busy_q;
	logic                          done_q;
	logic [STEP_W-1:0]             step_q;
	logic signed [CORDIC_W-1:0]    x_q;
	logic signed [CORDIC_W-1:0]    y_q;
	logic signed [ACC_ANGLE_W-1:0] z_q;
	logic signed [CORDIC_W-1:0]    xs0;
	logic signed [CORDIC_W-1:0]    ys0;
	logic signed [CORDIC_W-1:0]    x_sh;
	logic signed [CORDIC_W-1:0]    y_sh;
	logic signed [ACC_ANGLE_W-1:0] rot;
	logic                          both_zero;

	// operands scaled up before rotation
	assign xs0       = CORDIC_W'(den) <<< ACC_PRESCALE;
	assign ys0       = CORDIC_W'(num) <<< ACC_PRESCALE;
	assign both_zero = (num == 16'sd0) && (den == 16'sd0);
	assign x_sh      = x_q >>> step_q;
	assign y_sh      = y_q >>> step_q;
	assign rot       = atan_entry(step_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= !both_zero;
			done_q <= both_zero;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// quadrant pre-rotation then micro-rotations
	always_ff @(posedge clk) begin
		if (start) begin
			if (both_zero) begin
				z_q <= '0;
			end else if (!den[15]) begin
				x_q <= xs0;
				y_q <= ys0;
				z_q <= '0;
			end else if (!num[15]) begin
				x_q <= ys0;
				y_q <= -xs0;
				z_q <= ACC_ANGLE_W'(90 * 65536);
			end else begin
				x_q <= -ys0;
				y_q <= xs0;
				z_q <= -ACC_ANGLE_W'(90 * 65536);
			end
		end else if (busy_q) begin
			if (!y_q[CORDIC_W-1]) begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + rot;
			end else begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - rot;
			end
		end
	end

	assign done  = done_q;
	assign angle = z_q;

endmodule

`default_nettype wire

### rtl/core/imu_cf_merge.sv
// imu_cf_merge: blends the gyro pitch and roll with the accelerometer angles
// depends on imu_cf_pkg; multiply stage then round, shift and saturate stage
`default_nettype none

module imu_cf_merge import imu_cf_pkg::*; #(
	parameter int FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [15:0]                   alpha,
	input  wire logic signed [31:0]            angle_in [2],
	input  wire logic signed [ACC_ANGLE_W-1:0] acc_in [2],
	output logic                               done,
	output logic signed [31:0]                 angle_out [2]
);

	localparam int SHIFT_UP = 16 - FRAC_BITS;
	localparam int SHIFT_DN = 32 - FRAC_BITS;
	localparam logic signed [63:0] ROUND_V = 64'sd1 <<< (SHIFT_DN - 1);
	localparam logic signed [63:0] MAX_V = 64'sd2147483647;
	localparam logic signed [63:0] MIN_V = -64'sd2147483648;

	logic               mul_q;
	logic               add_q;
	logic               done_q;
	logic [16:0]        beta;
	logic signed [48:0] p_gyro_s1 [2];
	logic signed [43:0] p_acc_s1  [2];
	logic signed [63:0] total     [2];
	logic signed [63:0] scaled    [2];
	logic signed [31:0] res_q     [2];

	assign beta = 17'(17'h10000 - {1'b0, alpha});

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= 1'b0;
			add_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			mul_q <= start;
			add_q <= mul_q;
			if (start) begin
				done_q <= 1'b0;
			end else if (add_q) begin
				done_q <= 1'b1;
			end
		end
	end

	// weighted sum, rounding with ties upward
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			total[k]  = (64'(p_gyro_s1[k]) <<< SHIFT_UP) + 64'(p_acc_s1[k]) + ROUND_V;
			scaled[k] = total[k] >>> SHIFT_DN;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 2; k++) begin
			if (mul_q) begin
				p_gyro_s1[k] <= $signed({1'b0, alpha}) * angle_in[k];
				p_acc_s1[k]  <= $signed({1'b0, beta}) * acc_in[k];
			end
			if (add_q) begin
				if (scaled[k] > MAX_V) begin
					res_q[k] <= 32'sh7FFFFFFF;
				end else if (scaled[k] < MIN_V) begin
					res_q[k] <= 32'sh80000000;
				end else begin
					res_q[k] <= scaled[k][31:0];
				end
			end
		end
	end

	assign done      = done_q;
	assign angle_out = res_q;

endmodule

`default_nettype wire

### rtl/core/imu_complementary_filter_core.sv
// channel    | direction | carries
// in_ch      | sink      | sensor index, accel and gyro triples, elapsed ms
// out_ch     | source    | sensor tag, yaw, pitch, roll, correction flag
// cfg_ch     | sink      | register index and data, always ready
// one sample at a time, taken only in the idle state; the gyro lanes and the
// 16-step cordic lanes run side by side, and the blend stage follows when it runs
// a sample for a sensor beyond the configured count returns zero angles, flag clear
// reset clears angles and handshake state, and loads register defaults, at once
// a new sample is taken while the previous result waits on out_ch
// top level: gyro lanes, cordic lanes and blend stage; depends on imu_cf_pkg, imu_cf_ifs
`default_nettype none

module imu_complementary_filter_core import imu_cf_pkg::*; #(
	parameter int NUM_SENSORS     = NUM_SENSORS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	imu_cf_in_if.sink    in_ch,
	imu_cf_out_if.source out_ch,
	imu_cf_cfg_if.sink   cfg_ch
);

	localparam int SIDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_BLEND = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]         state_q;
	logic [1:0]         gyro_range_q;
	logic [15:0]        blend_w_q;
	logic [16:0]        mag_low_q;
	logic [16:0]        mag_high_q;
	logic signed [31:0] yaw_q   [NUM_SENSORS];
	logic signed [31:0] pitch_q [NUM_SENSORS];
	logic signed [31:0] roll_q  [NUM_SENSORS];
	logic               tag_q;
	logic               in_range_q;
	logic               corr_q;
	logic [SIDX_W-1:0]  idx_q;
	logic               out_valid_q;
	logic               out_tag_q;
	logic signed [31:0] out_yaw_q;
	logic signed [31:0] out_pitch_q;
	logic signed [31:0] out_roll_q;
	logic               out_corr_q;

	logic               accept;
	logic               in_range;
	logic [SIDX_W-1:0]  idx;
	logic [17:0]        mag;
	logic               lane_start;
	logic               merge_start;
	logic               lanes_done;
	logic               finish;
	logic               yaw_done, pitch_done, roll_done, accp_done, accr_done, merge_done;
	logic signed [31:0] yaw_new, pitch_new, roll_new;
	logic signed [ACC_ANGLE_W-1:0] acc_pitch, acc_roll;
	logic signed [31:0] blend_in  [2];
	logic signed [ACC_ANGLE_W-1:0] blend_acc [2];
	logic signed [31:0] blend_out [2];
	logic signed [31:0] fin_pitch, fin_roll;

	// input handshake and sample decode
	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign in_range    = 32'(in_ch.sensor_index) < NUM_SENSORS;
	assign idx         = SIDX_W'(in_ch.sensor_index);
	assign mag         = 18'(abs16(in_ch.accel_x)) + 18'(abs16(in_ch.accel_y))
		+ 18'(abs16(in_ch.accel_z));
	assign lane_start  = accept && in_range;

	// configuration registers
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_range_q <= GYRO_RANGE_RST;
			blend_w_q    <= BLEND_W_RST;
			mag_low_q    <= MAG_LOW_RST;
			mag_high_q   <= MAG_HIGH_RST;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_GYRO_RANGE: gyro_range_q <= cfg_ch.data[1:0];
				REG_BLEND_W:    blend_w_q    <= cfg_ch.data[15:0];
				REG_MAG_LOW:    mag_low_q    <= cfg_ch.data;
				REG_MAG_HIGH:   mag_high_q   <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	// gyro lanes
	imu_cf_gyro_lane #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
		.clk, .arst_n, .start(lane_start), .rate(in_ch.gyro_z), .ms(in_ch.elapsed_ms),
		.range_sel(gyro_range_q), .subtract(1'b0), .angle_in(yaw_q[idx]),
		.done(yaw_done), .angle_out(yaw_new)
	);
	imu_cf_gyro_lane #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
		.clk, .arst_n, .start(lane_start), .rate(in_ch.gyro_x), .ms(in_ch.elapsed_ms),
		.range_sel(gyro_range_q), .subtract(1'b0), .angle_in(pitch_q[idx]),
		.done(pitch_done), .angle_out(pitch_new)
	);
	imu_cf_gyro_lane #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
		.clk, .arst_n, .start(lane_start), .rate(in_ch.gyro_y), .ms(in_ch.elapsed_ms),
		.range_sel(gyro_range_q), .subtract(1'b1), .angle_in(roll_q[idx]),
		.done(roll_done), .angle_out(roll_new)
	);

	// accelerometer angle lanes
	imu_cf_cordic_lane u_acc_pitch (
		.clk, .arst_n, .start(lane_start), .num(in_ch.accel_y), .den(in_ch.accel_z),
		.done(accp_done), .angle(acc_pitch)
	);
	imu_cf_cordic_lane u_acc_roll (
		.clk, .arst_n, .start(lane_start), .num(in_ch.accel_x), .den(in_ch.accel_z),
		.done(accr_done), .angle(acc_roll)
	);

	// blend stage
	assign blend_in[0]  = pitch_new;
	assign blend_in[1]  = roll_new;
	assign blend_acc[0] = acc_pitch;
	assign blend_acc[1] = acc_roll;
	imu_cf_merge #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_merge (
		.clk, .arst_n, .start(merge_start), .alpha(blend_w_q), .angle_in(blend_in),
		.acc_in(blend_acc), .done(merge_done), .angle_out(blend_out)
	);

	assign lanes_done  = yaw_done && pitch_done && roll_done && accp_done && accr_done;
	assign merge_start = (state_q == ST_RUN) && lanes_done && corr_q;
	assign finish      = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);
	assign fin_pitch   = corr_q ? blend_out[0] : pitch_new;
	assign fin_roll    = corr_q ? blend_out[1] : roll_new;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:  if (accept) state_q <= in_range ? ST_RUN : ST_DONE;
				ST_RUN:   if (lanes_done) state_q <= corr_q ? ST_BLEND : ST_DONE;
				ST_BLEND: if (merge_done) state_q <= ST_DONE;
				ST_DONE:  if (finish) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// per-transaction context
	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q      <= in_ch.sensor_index;
			in_range_q <= in_range;
			idx_q      <= idx;
			corr_q     <= in_range && (mag > 18'(mag_low_q)) && (mag < 18'(mag_high_q));
		end
	end

	// angle state per sensor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SENSORS; s++) begin
				yaw_q[s]   <= '0;
				pitch_q[s] <= '0;
				roll_q[s]  <= '0;
			end
		end else if (finish && in_range_q) begin
			yaw_q[idx_q]   <= yaw_new;
			pitch_q[idx_q] <= fin_pitch;
			roll_q[idx_q]  <= fin_roll;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_tag_q   <= tag_q;
			out_yaw_q   <= in_range_q ? yaw_new : 32'sd0;
			out_pitch_q <= in_range_q ? fin_pitch : 32'sd0;
			out_roll_q  <= in_range_q ? fin_roll : 32'sd0;
			out_corr_q  <= corr_q;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.sensor_tag      = out_tag_q;
	assign out_ch.yaw_out         = out_yaw_q;
	assign out_ch.pitch_out       = out_pitch_q;
	assign out_ch.roll_out        = out_roll_q;
	assign out_ch.accel_corrected = out_corr_q;

	// checks
	a_merge_needs_corr: assert property (@(posedge clk) disable iff (!arst_n)
		merge_start |-> (corr_q && in_range_q))
		else $error("blend started without correction");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("sequencer idle after transaction");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> (!out_valid_q || out_ch.ready))
		else $error("pending result overwritten");
	a_corr_only_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && !in_range_q) |-> !corr_q)
		else $error("correction flagged for unknown sensor");

endmodule

`default_nettype wire

### bench/imu_complementary_filter_core_tb.sv
// testbench for the attitude filter core: directed and random samples checked against
// an in-bench predictor of gyro integration, cordic tilt angles and the blend
// depends on imu_cf_pkg, imu_cf_ifs and imu_complementary_filter_core
`timescale 1ns / 100ps

module imu_complementary_filter_core_tb;
	import imu_cf_pkg::*;

	typedef struct {
		logic               sensor_index;
		logic signed [15:0] accel_x, accel_y, accel_z;
		logic signed [15:0] gyro_x, gyro_y, gyro_z;
		logic [15:0]        elapsed_ms;
	} sample_t;

	typedef struct {
		logic               sensor_tag;
		logic signed [31:0] yaw, pitch, roll;
		logic               corrected;
	} attitude_t;

	localparam longint TILT_TABLE [16] = '{2949120, 1740967, 919879, 466945, 234379,
		117266, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
	localparam longint SENS_X10 [4] = '{1310, 655, 328, 164};
	localparam int FRAC = ANGLE_FRAC_BITS_DEF;

	logic clk;
	logic arst_n;
	imu_cf_in_if  in_ch();
	imu_cf_out_if out_ch();
	imu_cf_cfg_if cfg_ch();

	imu_complementary_filter_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	// predictor state
	logic [1:0]         p_range;
	logic [15:0]        p_weight;
	logic [16:0]        p_mag_low, p_mag_high;
	logic signed [31:0] p_yaw [2], p_pitch [2], p_roll [2];

	attitude_t expected_attitudes [$];
	int        errors = 0;
	int        hold_cnt;
	bit        hold_req;

	// clock and watchdog timeout
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#500_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint gyro_step(longint g, longint ms);
		longint mag, d, q;
		mag = g < 0 ? -g : g;
		d = SENS_X10[p_range] * 100;
		q = (((mag * ms) << FRAC) + d / 2) / d;
		return g < 0 ? -q : q;
	endfunction

	// vectoring cordic, degrees times 65536
	function automatic longint tilt_angle(longint y, longint x);
		longint z, t, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		x = x * 16384;
		y = y * 16384;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 90 * 65536;
			end else begin
				t = x; x = -y; y = t; z = -90 * 65536;
			end
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + TILT_TABLE[i];
			end else begin
				x = x - ys; y = y + xs; z = z - TILT_TABLE[i];
			end
		end
		return z;
	endfunction

	function automatic logic signed [31:0] blend_angle(logic signed [31:0] ang, longint acc);
		longint a, v;
		a = p_weight;
		v = a * (longint'(ang) * (64'sd1 << (16 - FRAC))) + (65536 - a) * acc;
		return sat32((v + (64'sd1 << (31 - FRAC))) >>> (32 - FRAC));
	endfunction

	function automatic attitude_t predict_attitude(sample_t s);
		attitude_t r;
		longint ax, ay, az, mag;
		int k;
		k = s.sensor_index;
		ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
		p_yaw[k]   = sat32(longint'(p_yaw[k]) + gyro_step(s.gyro_z, s.elapsed_ms));
		p_pitch[k] = sat32(longint'(p_pitch[k]) + gyro_step(s.gyro_x, s.elapsed_ms));
		p_roll[k]  = sat32(longint'(p_roll[k]) - gyro_step(s.gyro_y, s.elapsed_ms));
		mag = (ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay) + (az < 0 ? -az : az);
		r.corrected = (mag > p_mag_low) && (mag < p_mag_high);
		if (r.corrected) begin
			p_pitch[k] = blend_angle(p_pitch[k], tilt_angle(ay, az));
			p_roll[k]  = blend_angle(p_roll[k], tilt_angle(ax, az));
		end
		r.sensor_tag = s.sensor_index;
		r.yaw = p_yaw[k]; r.pitch = p_pitch[k]; r.roll = p_roll[k];
		return r;
	endfunction

	// one sample transaction, preceded by a random gap
	task automatic send_sample(sample_t s);
		int gap;
		gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 80);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.sensor_index <= s.sensor_index;
		in_ch.accel_x      <= s.accel_x;
		in_ch.accel_y      <= s.accel_y;
		in_ch.accel_z      <= s.accel_z;
		in_ch.gyro_x       <= s.gyro_x;
		in_ch.gyro_y       <= s.gyro_y;
		in_ch.gyro_z       <= s.gyro_z;
		in_ch.elapsed_ms   <= s.elapsed_ms;
		do @(posedge clk); while (!in_ch.ready);
		expected_attitudes.push_back(predict_attitude(s));
	endtask

	task automatic drain;
		in_ch.valid <= 1'b0;
		while (expected_attitudes.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [16:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_GYRO_RANGE: p_range    = val[1:0];
			REG_BLEND_W:    p_weight   = val[15:0];
			REG_MAG_LOW:    p_mag_low  = val;
			REG_MAG_HIGH:   p_mag_high = val;
			default: ;
		endcase
	endtask

	function automatic sample_t make_sample(logic si, int ax, int ay, int az, int gx, int gy,
		int gz, int ms);
		sample_t s;
		s.sensor_index = si;
		s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az);
		s.gyro_x = 16'(gx); s.gyro_y = 16'(gy); s.gyro_z = 16'(gz);
		s.elapsed_ms = 16'(ms);
		return s;
	endfunction

	// random sample: accel mostly within +-9000, sometimes over the full range
	function automatic sample_t random_sample();
		sample_t s;
		int lim;
		s.sensor_index = 1'($urandom_range(0, 1));
		lim = $urandom_range(0, 3) == 0 ? 32767 : 9000;
		s.accel_x = 16'($urandom_range(0, 2 * lim) - lim);
		s.accel_y = 16'($urandom_range(0, 2 * lim) - lim);
		s.accel_z = 16'($urandom_range(0, 2 * lim) - lim);
		if ($urandom_range(0, 9) == 0) s.accel_x = 16'($urandom);
		s.gyro_x = 16'($urandom);
		s.gyro_y = 16'($urandom);
		s.gyro_z = 16'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			s.gyro_x = s.gyro_x >>> 4; s.gyro_y = s.gyro_y >>> 4; s.gyro_z = s.gyro_z >>> 4;
		end
		s.elapsed_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
			16'($urandom_range(0, 40));
		return s;
	endfunction

	task automatic test_directed;
		send_sample(make_sample(0, 0, 0, 10000, 0, 0, 0, 10));
		send_sample(make_sample(0, 0, 0, -10000, 100, 100, 100, 10));
		send_sample(make_sample(1, 10000, 0, 0, 0, 0, 0, 5));
		send_sample(make_sample(1, 0, 10000, 0, 0, 0, 0, 5));
		send_sample(make_sample(0, 5000, -5000, -5000, 0, 0, 0, 0));
		send_sample(make_sample(1, -9000, 9000, -9000, -1, 1, -1, 1));
		send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0));
		send_sample(make_sample(0, -32768, -32768, -32768, 32767, -32768, 32767, 65535));
		send_sample(make_sample(0, 32767, 32767, 32767, 32767, -32768, 32767, 65535));
		send_sample(make_sample(1, 32767, -32768, 1, -32768, 32767, -32768, 65535));
		send_sample(make_sample(1, 4096, 4096, 0, -32768, 32767, -32768, 65535));
		send_sample(make_sample(0, 4096, 4096, 1, 0, 0, 0, 0));
		send_sample(make_sample(1, 100, -100, 8000, 131, -131, 131, 1000));
		// unused register indexes must leave everything alone
		drain();
		write_reg(3'd4, 17'h1ffff);
		write_reg(3'd7, 17'h00000);
		send_sample(make_sample(0, 3000, 3000, 3000, 50, 50, 50, 20));
		drain();
	endtask

	task automatic test_random_phase(logic [1:0] rng, logic [16:0] w, logic [16:0] lo,
		logic [16:0] hi, int n);
		write_reg(REG_GYRO_RANGE, rng);
		write_reg(REG_BLEND_W, w);
		write_reg(REG_MAG_LOW, lo);
		write_reg(REG_MAG_HIGH, hi);
		repeat (n) send_sample(random_sample());
		drain();
	endtask

	// receiver holds off while samples keep coming
	task automatic test_backpressure;
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		repeat (20) send_sample(random_sample());
		drain();
	endtask

	// long stall counter for the receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
		end else if (hold_req) begin
			hold_cnt <= 600;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if ($urandom_range(0, 199) == 0) begin
			hold_cnt <= $urandom_range(20, 120);
		end
	end

	// result checker and receiver idling
	always @(posedge clk) begin
		attitude_t e;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_attitudes.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
			end else begin
				e = expected_attitudes.pop_front();
				if (out_ch.sensor_tag !== e.sensor_tag) begin
					$error("sensor_tag expected %0d got %0d", e.sensor_tag, out_ch.sensor_tag);
					errors++;
				end
				if (out_ch.yaw_out !== e.yaw) begin
					$error("yaw_out expected %0d got %0d", e.yaw, out_ch.yaw_out);
					errors++;
				end
				if (out_ch.pitch_out !== e.pitch) begin
					$error("pitch_out expected %0d got %0d", e.pitch, out_ch.pitch_out);
					errors++;
				end
				if (out_ch.roll_out !== e.roll) begin
					$error("roll_out expected %0d got %0d", e.roll, out_ch.roll_out);
					errors++;
				end
				if (out_ch.accel_corrected !== e.corrected) begin
					$error("accel_corrected expected %0d got %0d", e.corrected,
						out_ch.accel_corrected);
					errors++;
				end
			end
		end
		if (!arst_n || hold_cnt > 0) out_ch.ready <= 1'b0;
		else out_ch.ready <= ($urandom_range(0, 9) < 7);
	end

	initial begin
		hold_req <= 1'b0;
		p_range = GYRO_RANGE_RST; p_weight = BLEND_W_RST;
		p_mag_low = MAG_LOW_RST; p_mag_high = MAG_HIGH_RST;
		for (int k = 0; k < 2; k++) begin
			p_yaw[k] = 0; p_pitch[k] = 0; p_roll[k] = 0;
		end
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0; in_ch.sensor_index <= 1'b0;
		in_ch.accel_x <= '0; in_ch.accel_y <= '0; in_ch.accel_z <= '0;
		in_ch.gyro_x <= '0; in_ch.gyro_y <= '0; in_ch.gyro_z <= '0;
		in_ch.elapsed_ms <= '0;
		cfg_ch.valid <= 1'b0; cfg_ch.index <= '0; cfg_ch.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		test_directed();
		test_random_phase(2'd0, 17'd64225, 17'd8192, 17'd32768, 250);
		test_random_phase(2'd3, 17'd65535, 17'd0, 17'd98304, 250);
		test_random_phase(2'd1, 17'd0, 17'd1000, 17'd20000, 250);
		test_backpressure();
		test_random_phase(2'd2, 17'h1ffff, 17'd98304, 17'd0, 200);
		test_random_phase(2'd3, 17'd32768, 17'd0, 17'h1ffff, 250);
		test_random_phase(2'd1, 17'd1, 17'd5000, 17'd30000, 300);

		if (errors == 0 && expected_attitudes.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
